// ===== rtl/scr_pkg.sv =====
// Shared types and constants for the sample change reporter.
// Used by the register block, controller, datapath and top level.
package scr_pkg;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_PERIOD   = 1'b0;
	localparam logic REG_DEADBAND = 1'b1;

	// Reset values
	localparam logic [15:0] PERIOD_RESET   = 16'd20;
	localparam logic [9:0]  DEADBAND_RESET = 10'd4;
	localparam logic [15:0] LAST_RESET     = 16'hFFFF;

	// Printing limits and divide-by-ten reciprocal
	localparam int          NUM_DIGITS  = 4;
	localparam logic [13:0] MAX_PRINT   = 14'd9999;
	localparam logic [16:0] DIV10_MUL   = 17'd52429;
	localparam int          DIV10_SHIFT = 19;

	// Report text characters
	localparam logic [7:0] CHAR_A    = 8'h41;
	localparam logic [7:0] CHAR_D    = 8'h44;
	localparam logic [7:0] CHAR_C    = 8'h43;
	localparam logic [7:0] CHAR_EQ   = 8'h3D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // take the sample, bump the tick counter
		logic commit;     // report: clear counter, store sample, start conversion
		logic conv_step;  // peel off one decimal digit
		logic emit_adv;   // advance to the next character
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fire;       // report condition met
		logic conv_done;  // this step produced the last digit
		logic last_pos;   // current character is the final LF
	} sts_t;

endpackage

// ===== rtl/scr_sample_if.sv =====
// Input channel carrying one converter sample per tick.
// Valid/ready handshake; no package dependency.
interface scr_sample_if #(
	parameter int SAMPLE_BITS = 10
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/scr_char_if.sv =====
// Output channel carrying one report character per request.
// Valid/ready handshake; no package dependency.
interface scr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ===== rtl/scr_regs.sv =====
// APB-style configuration registers: report period and deadband.
// Depends on scr_pkg for register indexes and reset values.
module scr_regs
	import scr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] report_period,
	output logic [9:0]  deadband
);

	logic [15:0] period_q;
	logic [9:0]  deadband_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RESET;
			deadband_q <= DEADBAND_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_PERIOD) begin
				period_q <= pwdata[15:0];
			end else begin
				deadband_q <= pwdata[9:0];
			end
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == REG_PERIOD) begin
			prdata = {16'd0, period_q};
		end else begin
			prdata = {22'd0, deadband_q};
		end
	end

	assign report_period = period_q;
	assign deadband      = deadband_q;

endmodule

// ===== rtl/scr_ctrl.sv =====
// Controller state machine: sequences decide, digit conversion and emission.
// Depends on scr_pkg for state, command and status types.
module scr_ctrl
	import scr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.fire) begin
					cmd.commit = 1'b1;
					state_d    = ST_CONV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.emit_adv = 1'b1;
					if (sts.last_pos) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/scr_dp.sv =====
// Datapath: tick counter, last reported value, change test,
// divide-by-ten digit extraction and the character mux. Depends on scr_pkg.
module scr_dp
	import scr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [15:0]            report_period,
	input  logic [9:0]             deadband,
	output logic [7:0]             out_char,
	output logic                   last_char
);

	logic [SAMPLE_BITS-1:0] sample_q;
	logic [15:0]            tick_q;
	logic [15:0]            last_q;
	logic [13:0]            val_q;
	logic [3:0]             dig_q [NUM_DIGITS];
	logic [2:0]             nd_q;
	logic [3:0]             pos_q;

	logic [15:0] sample_w;
	logic [16:0] sample_x;
	logic [16:0] last_x;
	logic [16:0] db_x;
	logic [30:0] prod;
	logic [13:0] quot;
	logic [13:0] quot10;
	logic [3:0]  rem;
	logic [13:0] sat_val;
	logic [3:0]  nd_x;
	logic [3:0]  didx;

	// Report test: period reached, or a change beyond the deadband, with widened sums so nothing wraps
	assign sample_w = 16'(sample_q);
	assign sample_x = 17'(sample_q);
	assign last_x   = {1'b0, last_q};
	assign db_x     = 17'(deadband);
	assign sts.fire = (tick_q >= report_period)
		|| (sample_x > last_x + db_x)
		|| (last_x > sample_x + db_x);

	// Clamp the printed value
	assign sat_val = (sample_w > 16'(MAX_PRINT)) ? MAX_PRINT : sample_w[13:0];

	// Divide by ten via reciprocal multiply, remainder by shift-add
	assign prod   = 31'(val_q) * 31'(DIV10_MUL);
	assign quot   = 14'(prod >> DIV10_SHIFT);
	assign quot10 = 14'({quot, 3'b000}) + 14'({quot, 1'b0});
	assign rem    = 4'(val_q - quot10);
	assign sts.conv_done = (quot == 14'd0) || (nd_q == 3'(NUM_DIGITS - 1));

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= 16'd0;
			last_q <= LAST_RESET;
			nd_q   <= 3'd0;
			pos_q  <= 4'd0;
		end else begin
			if (cmd.load) begin
				tick_q <= tick_q + 16'd1;
			end else if (cmd.commit) begin
				tick_q <= 16'd0;
			end
			if (cmd.commit) begin
				last_q <= sample_w;
				nd_q   <= 3'd0;
				pos_q  <= 4'd0;
			end else if (cmd.conv_step) begin
				nd_q <= nd_q + 3'd1;
			end
			if (cmd.emit_adv) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.commit) begin
			val_q <= sat_val;
		end else if (cmd.conv_step) begin
			val_q             <= quot;
			dig_q[nd_q[1:0]] <= rem;
		end
	end

	// Character select: header, digits most significant first, CR, LF
	assign nd_x = {1'b0, nd_q};
	assign didx = nd_x + 4'd3 - pos_q;
	assign sts.last_pos = (pos_q == nd_x + 4'd5);
	assign last_char    = sts.last_pos;

	always_comb begin
		priority if (pos_q == 4'd0) begin
			out_char = CHAR_A;
		end else if (pos_q == 4'd1) begin
			out_char = CHAR_D;
		end else if (pos_q == 4'd2) begin
			out_char = CHAR_C;
		end else if (pos_q == 4'd3) begin
			out_char = CHAR_EQ;
		end else if (pos_q < nd_x + 4'd4) begin
			out_char = CHAR_ZERO + 8'(dig_q[didx[1:0]]);
		end else if (pos_q == nd_x + 4'd4) begin
			out_char = CHAR_CR;
		end else begin
			out_char = CHAR_LF;
		end
	end

endmodule

// ===== rtl/sample_change_reporter_core.sv =====
// Sample change reporter: one converter sample per tick in, report text out.
//
// The samples channel takes one sample per tick. The block bumps its tick
// counter and reports when the counter reaches report_period or when the
// sample moves by more than deadband from the last reported value. A report
// is the text "ADC=", the decimal value (no leading zeros, at most four
// digits) and CR LF, one character per request on the chars channel, with
// last_char set on the LF.
// Flow: a sample is taken in the idle cycle and the decision follows in the
// next cycle; a tick without a report then returns to idle and frees the input.
// A report then has the divide-by-ten unit peel off one digit per cycle and
// sends one character per cycle while the receiver keeps ready high. One tick
// is worked on at a time; the input is not ready until the last character of
// a report has been taken.
// When the receiver stalls, the current character holds until accepted.
// Reset clears the tick counter, sets the last reported value to 65535 so
// the first tick always reports, and loads period 20 and deadband 4.
// Configuration goes through the APB port: period at 0x0, deadband at 0x4.
module sample_change_reporter_core
	import scr_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	scr_sample_if.sink  samples,
	scr_char_if.source  chars,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] report_period;
	logic [9:0]  deadband;
	cmd_t        cmd;
	sts_t        sts;

	// Configuration registers
	scr_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.report_period (report_period),
		.deadband      (deadband)
	);

	// Sequencer
	scr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	scr_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.sample        (samples.sample),
		.report_period (report_period),
		.deadband      (deadband),
		.out_char      (chars.out_char),
		.last_char     (chars.last_char)
	);

`ifndef SYNTHESIS
	// A taken sample blocks the input until its decision is made
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("input ready right after a sample was taken");

	// The final character of a report is always LF
	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.last_char |-> chars.out_char == CHAR_LF)
		else $error("last_char set on a character other than LF");

	// Taking the final character frees the input
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready && chars.last_char |=> samples.ready && !chars.valid)
		else $error("block not idle after report end");

	// Input and output never handshake in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(samples.ready && chars.valid))
		else $error("input ready while a report character is pending");
`endif

endmodule

// ===== tb/sample_change_reporter_core_tb.sv =====
// Self-checking testbench for sample_change_reporter_core: drives ticks, predicts report text.
// Depends on scr_pkg, scr_sample_if, scr_char_if and sample_change_reporter_core (with its submodules) from the RTL.
module sample_change_reporter_core_tb;
	import scr_pkg::*;

	localparam int SAMPLE_BITS    = 10;
	localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} report_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	scr_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	scr_char_if char_ch ();

	sample_change_reporter_core #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
		.clk,
		.arst_n,
		.samples(sample_ch),
		.chars(char_ch),
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	// Predictor state and configuration copy
	logic [15:0] period_setting     = PERIOD_RESET;
	logic [9:0]  deadband_setting   = DEADBAND_RESET;
	logic [15:0] last_reported_val  = LAST_RESET;
	logic [15:0] ticks_since_report = '0;

	logic [SAMPLE_BITS-1:0] pending_samples[$];
	report_char_t           expected_chars[$];

	// Directed ticks at reset settings: first tick, deadband edges, zero, full scale
	int directed_vals[17] = '{512, 516, 517, 513, 512, 0, 4, 5, 1023, 1019, 1018,
		341, 682, 9, 1000, 99, 999};

	int samples_queued   = 0;
	int samples_accepted = 0;
	int reports_expected = 0;
	int chars_checked    = 0;
	int reg_writes       = 0;
	int mismatches       = 0;
	int handshakes       = 0;
	int send_idle_pct    = 0;
	int recv_stall_pct   = 0;
	int holdoff_reqs     = 0;
	int walk_pos         = 512;
	bit sample_taken     = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= MAX_SHOWN) begin
			$display("ERROR: %s", msg);
		end
	endtask

	// Advance the tick counter and queue the report text if this tick fires
	function automatic void predict_report(input logic [SAMPLE_BITS-1:0] smp);
		int unsigned s_w    = smp;
		int unsigned last_w = last_reported_val;
		int unsigned db_w   = deadband_setting;
		string       txt;
		ticks_since_report = ticks_since_report + 16'd1;
		if (ticks_since_report >= period_setting || s_w > last_w + db_w
				|| last_w > s_w + db_w) begin
			ticks_since_report = '0;
			last_reported_val  = 16'(smp);
			reports_expected++;
			txt = $sformatf("ADC=%0d", (s_w > 9999) ? 9999 : s_w);
			foreach (txt[i]) begin
				expected_chars.push_back('{code: txt[i], last: 1'b0});
			end
			expected_chars.push_back('{code: CHAR_CR, last: 1'b0});
			expected_chars.push_back('{code: CHAR_LF, last: 1'b1});
		end
	endfunction

	// Monitor: predict on each accepted sample, check each accepted character
	always @(posedge clk) begin : monitor
		report_char_t want;
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				predict_report(sample_ch.sample);
				sample_taken = 1'b1;
				samples_accepted++;
				handshakes++;
			end
			if (char_ch.valid && char_ch.ready) begin
				handshakes++;
				chars_checked++;
				if (expected_chars.size() == 0) begin
					flag_error($sformatf("unexpected char 0x%02h last=%0b",
						char_ch.out_char, char_ch.last_char));
				end else begin
					want = expected_chars.pop_front();
					if (char_ch.out_char !== want.code || char_ch.last_char !== want.last) begin
						flag_error($sformatf("char 0x%02h last=%0b, expected 0x%02h last=%0b",
							char_ch.out_char, char_ch.last_char, want.code, want.last));
					end
				end
			end
		end
	end

	// Sample driver: hold the offered sample until taken, then offer the next or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
		end else if (sample_ch.valid && !sample_taken) begin
			sample_ch.valid <= 1'b1;
		end else if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			sample_ch.valid  <= 1'b1;
			sample_ch.sample <= pending_samples.pop_front();
		end else begin
			sample_ch.valid <= 1'b0;
		end
		sample_taken = 1'b0;
	end

	// Character receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin : receiver
		int holdoff_left;
		int holdoff_done;
		if (!arst_n) begin
			char_ch.ready <= 1'b0;
			holdoff_left = 0;
			holdoff_done = 0;
		end else if (holdoff_done != holdoff_reqs) begin
			holdoff_done = holdoff_reqs;
			holdoff_left = HOLDOFF_CYCLES - 1;
			char_ch.ready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left--;
			char_ch.ready <= 1'b0;
		end else begin
			char_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: drop the run when no request moves for too long
	always @(negedge clk) begin : watchdog
		int seen;
		int quiet_cycles;
		if (handshakes != seen) begin
			seen = handshakes;
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL sample_change_reporter_core");
			$finish;
		end
	end

	task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_reg(input logic idx, input logic [31:0] want_val);
		logic [31:0] got;
		apb_access(idx, 1'b0, '0, got);
		if (got !== want_val) begin
			flag_error($sformatf("register %0d reads 0x%08h, expected 0x%08h", idx, got, want_val));
		end
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		logic [31:0] unused;
		apb_access(idx, 1'b1, val, unused);
		reg_writes++;
		if (idx == REG_PERIOD) begin
			period_setting = val[15:0];
			check_reg(idx, {16'b0, val[15:0]});
		end else begin
			deadband_setting = val[9:0];
			check_reg(idx, {22'b0, val[9:0]});
		end
	endtask

	// Wait until every sample is taken and every character has come, then let the block settle
	task automatic wait_drained();
		while (samples_accepted != samples_queued || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_phase(input int period, input int deadband, input int send_pct,
			input int recv_pct);
		wait_drained();
		write_reg(REG_PERIOD, 32'(period));
		write_reg(REG_DEADBAND, 32'(deadband));
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic queue_sample(input int v);
		pending_samples.push_back(SAMPLE_BITS'(v));
		samples_queued++;
	endtask

	// Random walk around the last value, sized to the deadband, with some jumps
	task automatic queue_walk(input int count);
		int r;
		int span;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			span = 2 * int'(deadband_setting) + 3;
			if (r < 10) begin
				walk_pos = $urandom_range(0, SAMPLE_MAX);
			end else if (r < 18) begin
				walk_pos = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
			end else begin
				walk_pos = walk_pos + $urandom_range(0, 2 * span) - span;
				if (walk_pos < 0) walk_pos = 0;
				if (walk_pos > SAMPLE_MAX) walk_pos = SAMPLE_MAX;
			end
			queue_sample(walk_pos);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		char_ch.ready    = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values of both registers
		check_reg(REG_PERIOD, {16'b0, PERIOD_RESET});
		check_reg(REG_DEADBAND, {22'b0, DEADBAND_RESET});

		// Directed at reset settings: first tick, deadband edges both ways, zero, full scale
		foreach (directed_vals[i]) begin
			queue_sample(directed_vals[i]);
		end

		// Period forcing with changes masked by the widest deadband
		set_phase(3, 1023, 0, 0);
		repeat (6) queue_sample(600);
		set_phase(1, 1023, 0, 0);
		repeat (2) queue_sample(600);
		set_phase(0, 1023, 0, 0);
		repeat (2) queue_sample(600);

		// Lower the period below the running count: the next tick reports
		set_phase(1000, 1023, 0, 0);
		repeat (8) queue_sample(300);
		set_phase(5, 1023, 0, 0);
		queue_sample(300);

		// Random phases over several settings and idle mixes
		set_phase(8, 0, 0, 0);
		queue_walk(60);
		set_phase(65535, 12, 56, 0);
		queue_walk(50);
		set_phase(4, 1023, 0, 56);
		queue_walk(50);
		set_phase($urandom_range(2, 30), $urandom_range(0, 40), 15, 15);
		queue_walk(30);
		// Hold off the receiver while samples keep coming, so the input stalls
		holdoff_reqs++;
		queue_walk(30);
		// Pause the sender until every report has come
		wait_drained();
		queue_walk(30);

		wait_drained();
		if (expected_chars.size() != 0) begin
			flag_error($sformatf("%0d characters never arrived", expected_chars.size()));
		end
		$display("Covered %0d ticks, %0d reports, %0d characters, %0d register writes.",
			samples_accepted, reports_expected, chars_checked, reg_writes);
		$display("Periods 0 to 65535, deadbands 0 to 1023, four idle mixes; %0d mismatches.",
			mismatches);
		if (mismatches == 0) begin
			$display("PASS sample_change_reporter_core");
		end else begin
			$display("FAIL sample_change_reporter_core");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/scr_pkg.sv
rtl/scr_sample_if.sv
rtl/scr_char_if.sv
rtl/scr_regs.sv
rtl/scr_ctrl.sv
rtl/scr_dp.sv
rtl/sample_change_reporter_core.sv
tb/sample_change_reporter_core_tb.sv
